// ===== rtl/scaled_cholesky_factor_unit_macros.svh =====
`ifndef SCALED_CHOLESKY_FACTOR_UNIT_MACROS_SVH
`define SCALED_CHOLESKY_FACTOR_UNIT_MACROS_SVH

// concurrent check, quiet while reset is high
`define SCF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scf check failed");

// concurrent check that also holds across reset
`define SCF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("scf check failed");

`endif

// ===== rtl/scf_pkg.sv =====
package scf_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int Q_FRAC = 16;
   localparam int DIVIDEND_WIDTH = 48;
   localparam int REM_WIDTH = 34;
   localparam int DIV_STEPS = 48;
   localparam int ROOT_STEPS = 24;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_FACTOR = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_NOT_PD       = 2'd1;
   localparam logic [1:0] ST_RANGE        = 2'd2;
   localparam logic [1:0] ST_NOT_FACTORED = 2'd3;

   localparam logic CSR_ORDER = 1'b0;
   localparam logic CSR_SCALE = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_CLEAR, S_ROW, S_RDA, S_RDB, S_MULG, S_ACC,
      S_SRD, S_SMUL, S_SSAT, S_DIFF, S_DEC, S_GRD, S_GDATA, S_WAIT, S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic root;
   } ds_cmd_type;

   function automatic logic signed [DATA_WIDTH-1:0] sat65(input logic signed [64:0] x);
      logic signed [64:0] hi;
      logic signed [64:0] lo;
      hi = 65'sd2147483647;
      lo = -65'sd2147483648;
      if (x > hi) return hi[DATA_WIDTH-1:0];
      else if (x < lo) return lo[DATA_WIDTH-1:0];
      else return x[DATA_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/scf_ram.sv =====
module scf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/scf_divsqrt.sv =====
module scf_divsqrt (
   input  logic                                   clock,
   input  logic                                   reset,
   input  scf_pkg::ds_cmd_type                    cmd,
   input  logic [scf_pkg::DIVIDEND_WIDTH-1:0]     operand,
   input  logic [scf_pkg::DATA_WIDTH-1:0]         divisor,
   output logic                                   done,
   output logic [scf_pkg::DIVIDEND_WIDTH-1:0]     result
);

   localparam int W = scf_pkg::DIVIDEND_WIDTH;
   localparam int R = scf_pkg::REM_WIDTH;

   logic [W-1:0]  work_ff, work_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [R-1:0]  rem_ff, rem_in;
   logic [scf_pkg::DATA_WIDTH-1:0] div_ff, div_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          root_ff, root_in;
   logic          done_ff, done_in;
   logic [R-1:0]  cand;
   logic [R-1:0]  sub;
   logic [R:0]    diff;
   logic          ge;

   always_comb begin
      cand = root_ff ? {rem_ff[R-3:0], work_ff[W-1:W-2]} : {rem_ff[R-2:0], work_ff[W-1]};
      sub  = root_ff ? {quo_ff[R-3:0], 2'b01} : {2'b00, div_ff};
      diff = {1'b0, cand} - {1'b0, sub};
      ge   = !diff[R];
   end

   always_comb begin
      work_in = work_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      root_in = root_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         work_in = operand;
         quo_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         root_in = cmd.root;
         cnt_in  = cmd.root ? 6'(scf_pkg::ROOT_STEPS - 1) : 6'(scf_pkg::DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[R-1:0] : cand;
         quo_in  = {quo_ff[W-2:0], ge};
         work_in = root_ff ? {work_ff[W-3:0], 2'b00} : {work_ff[W-2:0], 1'b0};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;

endmodule

// ===== rtl/scaled_cholesky_factor_unit.sv =====
// scaled cholesky factor unit
// req channel: one item per command, tdata = op, row, col, value (Q16.16).
//   op write stores A[row][col]; op factor computes lower-triangular G with
//   G*G^T = scale*A over the leading n x n block; op read returns G[row][col].
// rsp channel: one item per write, factor and read (op 3 gives none),
//   tdata = read_value, status (ok, not positive definite, range, not factored).
// csr channel: index 0 order n, index 1 scale (unsigned Q15.16), always ready,
//   to be written only while no command is in flight; not enforced by the block.
// a write answers on rsp in the next cycle, a read after S_READ; one item at a time.
// factor: S_CLEAR zeroes the factor memory, then per entry G[k][i] a dot
//   product over the single multiplier (S_ROW, S_RDA, S_RDB, S_MULG, S_ACC
//   per term), scaling (S_SRD, S_SMUL, S_SSAT, S_DIFF, S_DEC) and the shared
//   shift-subtract unit: 24 steps for a diagonal square root, or S_GRD and
//   S_GDATA reads then 48 steps for an off-diagonal divide.
// reset clears control state and the factored flag; A and G memories hold
//   no defined value until written.
// a stalled rsp holds its item in the output register; req_tready stays low
//   until the register is free or being drained.
module scaled_cholesky_factor_unit #(
   parameter int MAX_ORDER = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // op[1:0], row[4:2], col[7:5], value[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[31:0], status[33:32], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_data
);

   localparam int DW = scf_pkg::DATA_WIDTH;
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int IW = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;
   localparam int NW = $clog2(MAX_ORDER + 1);

   scf_pkg::state_type state_ff, state_in;

   logic [3:0]  msize_ff, msize_in;
   logic [30:0] scale_ff, scale_in;
   logic        fvalid_ff, fvalid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [1:0]  status_ff, status_in;
   logic [IW-1:0] k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [DW-1:0] opa_ff, opa_in;
   logic signed [DW-1:0] scaled_ff, scaled_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic        neg_ff, neg_in;

   logic [1:0]  r_op;
   logic [2:0]  r_row, r_col;
   logic [DW-1:0] r_value;
   logic        accept;
   logic        slot_free;
   logic [NW-1:0] n_w;

   logic          a_wr_en;
   logic [AW-1:0] a_wr_addr, a_rd_addr;
   logic [DW-1:0] a_rd_data;
   logic          g_wr_en;
   logic [AW-1:0] g_wr_addr, g_rd_addr;
   logic [DW-1:0] g_wr_data, g_rd_data;

   scf_pkg::ds_cmd_type ds_cmd;
   logic [scf_pkg::DIVIDEND_WIDTH-1:0] ds_operand, ds_result;
   logic [DW-1:0] ds_divisor;
   logic          ds_done;

   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [DW-1:0] g_fixed;
   logic [DW-1:0] wr_val;
   logic signed [DW-1:0] d_abs;

   function automatic logic [AW-1:0] addr_of(input int r, input int c);
      return AW'(r * MAX_ORDER + c);
   endfunction

   assign r_op    = req_tdata[1:0];
   assign r_row   = req_tdata[4:2];
   assign r_col   = req_tdata[7:5];
   assign r_value = req_tdata[39:8];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == scf_pkg::S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (msize_ff == 4'd0) n_w = NW'(1);
      else if (int'(msize_ff) > MAX_ORDER) n_w = NW'(MAX_ORDER);
      else n_w = NW'(msize_ff);
   end

   // memories
   scf_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (r_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   scf_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_g_ram (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   scf_divsqrt u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ds_cmd),
      .operand (ds_operand),
      .divisor (ds_divisor),
      .done    (ds_done),
      .result  (ds_result)
   );

   always_comb begin
      a_wr_en   = accept && (r_op == scf_pkg::OP_WRITE)
                  && (int'(r_row) < MAX_ORDER) && (int'(r_col) < MAX_ORDER);
      a_wr_addr = addr_of(int'(r_row), int'(r_col));
      a_rd_addr = addr_of(int'(k_ff), int'(i_ff));
   end

   always_comb begin
      case (state_ff)
         scf_pkg::S_RDA: g_rd_addr = addr_of(int'(i_ff), int'(j_ff));
         scf_pkg::S_RDB: g_rd_addr = addr_of(int'(k_ff), int'(j_ff));
         scf_pkg::S_GRD: g_rd_addr = addr_of(int'(i_ff), int'(i_ff));
         default:        g_rd_addr = addr_of(int'(r_row), int'(r_col));
      endcase
   end

   // shared multiplier operands
   always_comb begin
      if (state_ff == scf_pkg::S_SMUL) begin
         mul_a = signed'({1'b0, scale_ff});
         mul_b = signed'(a_rd_data);
      end else begin
         mul_a = opa_ff;
         mul_b = signed'(g_rd_data);
      end
   end

   always_comb begin
      g_fixed    = (signed'(g_rd_data) <= 0) ? DW'(1) : signed'(g_rd_data);
      d_abs      = d_ff[DW-1] ? -d_ff : d_ff;
      ds_divisor = g_fixed;
      ds_cmd.start = 1'b0;
      ds_cmd.root  = 1'b0;
      ds_operand   = {d_abs, 16'b0};
      if (state_ff == scf_pkg::S_DEC && i_ff == k_ff && d_ff > 0) begin
         ds_cmd.start = 1'b1;
         ds_cmd.root  = 1'b1;
         ds_operand   = {d_ff, 16'b0};
      end else if (state_ff == scf_pkg::S_GDATA) begin
         ds_cmd.start = 1'b1;
      end
   end

   always_comb begin
      if (i_ff == k_ff) begin
         wr_val = ds_result[DW-1:0];
      end else if (neg_ff) begin
         if (ds_result > 48'h0000_8000_0000) wr_val = 32'h8000_0000;
         else wr_val = -ds_result[DW-1:0];
      end else begin
         if (ds_result > 48'h0000_7FFF_FFFF) wr_val = 32'h7FFF_FFFF;
         else wr_val = ds_result[DW-1:0];
      end
   end

   always_comb begin
      g_wr_en   = 1'b0;
      g_wr_addr = clr_ff;
      g_wr_data = '0;
      if (state_ff == scf_pkg::S_CLEAR) begin
         g_wr_en = 1'b1;
      end else if (state_ff == scf_pkg::S_WAIT && ds_done) begin
         g_wr_en   = 1'b1;
         g_wr_addr = addr_of(int'(k_ff), int'(i_ff));
         g_wr_data = wr_val;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scf_pkg::S_IDLE: begin
            if (accept && r_op == scf_pkg::OP_READ) state_in = scf_pkg::S_READ;
            else if (accept && r_op == scf_pkg::OP_FACTOR) state_in = scf_pkg::S_CLEAR;
         end
         scf_pkg::S_READ:  state_in = scf_pkg::S_IDLE;
         scf_pkg::S_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = scf_pkg::S_ROW;
         end
         scf_pkg::S_ROW:   state_in = (j_ff < i_ff) ? scf_pkg::S_RDA : scf_pkg::S_SRD;
         scf_pkg::S_RDA:   state_in = scf_pkg::S_RDB;
         scf_pkg::S_RDB:   state_in = scf_pkg::S_MULG;
         scf_pkg::S_MULG:  state_in = scf_pkg::S_ACC;
         scf_pkg::S_ACC:   state_in = scf_pkg::S_ROW;
         scf_pkg::S_SRD:   state_in = scf_pkg::S_SMUL;
         scf_pkg::S_SMUL:  state_in = scf_pkg::S_SSAT;
         scf_pkg::S_SSAT:  state_in = scf_pkg::S_DIFF;
         scf_pkg::S_DIFF:  state_in = scf_pkg::S_DEC;
         scf_pkg::S_DEC: begin
            if (i_ff != k_ff) state_in = scf_pkg::S_GRD;
            else if (d_ff > 0) state_in = scf_pkg::S_WAIT;
            else state_in = scf_pkg::S_DONE;
         end
         scf_pkg::S_GRD:   state_in = scf_pkg::S_GDATA;
         scf_pkg::S_GDATA: state_in = scf_pkg::S_WAIT;
         scf_pkg::S_WAIT: begin
            if (ds_done) begin
               if (i_ff == k_ff && NW'(k_ff) + NW'(1) == n_w) state_in = scf_pkg::S_DONE;
               else state_in = scf_pkg::S_ROW;
            end
         end
         scf_pkg::S_DONE: begin
            if (slot_free) state_in = scf_pkg::S_IDLE;
         end
         default: state_in = scf_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      msize_in      = msize_ff;
      scale_in      = scale_ff;
      fvalid_in     = fvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      status_in     = status_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      clr_in        = clr_ff;
      acc_in        = acc_ff;
      prod_in       = mul_a * mul_b;
      opa_in        = opa_ff;
      scaled_in     = scaled_ff;
      d_in          = d_ff;
      neg_in        = neg_ff;

      if (csr_valid) begin
         if (csr_index == scf_pkg::CSR_ORDER) msize_in = csr_data[3:0];
         else scale_in = csr_data;
      end

      case (state_ff)
         scf_pkg::S_IDLE: begin
            if (accept && r_op == scf_pkg::OP_WRITE) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = ((int'(r_row) < MAX_ORDER) && (int'(r_col) < MAX_ORDER))
                               ? scf_pkg::ST_OK : scf_pkg::ST_RANGE;
            end else if (accept && r_op == scf_pkg::OP_READ) begin
               if (!fvalid_ff) status_in = scf_pkg::ST_NOT_FACTORED;
               else if (int'(r_row) >= int'(n_w) || int'(r_col) >= int'(n_w))
                  status_in = scf_pkg::ST_RANGE;
               else status_in = scf_pkg::ST_OK;
            end else if (accept && r_op == scf_pkg::OP_FACTOR) begin
               clr_in = '0;
            end
         end
         scf_pkg::S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_value_in  = (status_ff == scf_pkg::ST_OK) ? g_rd_data : '0;
         end
         scf_pkg::S_CLEAR: begin
            clr_in    = clr_ff + AW'(1);
            k_in      = '0;
            i_in      = '0;
            j_in      = '0;
            acc_in    = '0;
            status_in = scf_pkg::ST_OK;
         end
         scf_pkg::S_RDB:  opa_in = signed'(g_rd_data);
         scf_pkg::S_ACC: begin
            acc_in = acc_ff + (prod_ff >>> scf_pkg::Q_FRAC);
            j_in   = j_ff + IW'(1);
         end
         scf_pkg::S_SSAT: scaled_in = scf_pkg::sat65(65'(prod_ff >>> scf_pkg::Q_FRAC));
         scf_pkg::S_DIFF: d_in = scf_pkg::sat65(65'(scaled_ff) - 65'(acc_ff));
         scf_pkg::S_DEC: begin
            neg_in = d_ff[DW-1];
            if (i_ff == k_ff && !(d_ff > 0)) status_in = scf_pkg::ST_NOT_PD;
         end
         scf_pkg::S_WAIT: begin
            if (ds_done) begin
               acc_in = '0;
               j_in   = '0;
               if (i_ff == k_ff) begin
                  k_in = k_ff + IW'(1);
                  i_in = '0;
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         scf_pkg::S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = status_ff;
               fvalid_in     = (status_ff == scf_pkg::ST_OK);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scf_pkg::S_IDLE;
         msize_ff     <= 4'd1;
         scale_ff     <= 31'd65536;
         fvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         msize_ff     <= msize_in;
         scale_ff     <= scale_in;
         fvalid_ff    <= fvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      status_ff     <= status_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      clr_ff        <= clr_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      opa_ff        <= opa_in;
      scaled_ff     <= scaled_in;
      d_ff          <= d_in;
      neg_ff        <= neg_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_value_ff};

endmodule

// ===== rtl/scf_checker.sv =====
`include "scaled_cholesky_factor_unit_macros.svh"

module scf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   logic [1:0] req_op;
   logic [1:0] rsp_status;
   logic       req_take;

   assign req_op     = req_tdata[1:0];
   assign rsp_status = rsp_tdata[33:32];
   assign req_take   = req_tvalid && req_tready;

   `SCF_ASSERT(rsp_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `SCF_ASSERT_ALWAYS(rsp_idle_after_reset, clock, reset |=> !rsp_tvalid)
   `SCF_ASSERT(error_value_zero, clock, reset, rsp_tvalid && rsp_status != scf_pkg::ST_OK |-> rsp_tdata[31:0] == 32'd0)
   `SCF_ASSERT(write_answers_next, clock, reset, req_take && req_op == scf_pkg::OP_WRITE |=> rsp_tvalid)
   `SCF_ASSERT(unused_op_silent, clock, reset, req_take && req_op == scf_pkg::OP_NOP |=> !rsp_tvalid)

endmodule

bind scaled_cholesky_factor_unit scf_checker u_scf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
